// ===== hdl/arp_resolver_with_aging_cache_defines.svh =====
// Assertion macros shared by the checker of the ARP resolver.
// Depends on nothing; expects aclk and aresetn in the scope of use.
`ifndef ARP_RESOLVER_WITH_AGING_CACHE_DEFINES_SVH
`define ARP_RESOLVER_WITH_AGING_CACHE_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define ARC_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define ARC_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/arc_pkg.sv =====
// Types, codes and constants of the ARP resolver with aging cache.
// Used by every module of the block; depends on nothing.
package arc_pkg;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 64;
    localparam int MS_W   = 32;
    localparam int KIND_W = 3;
    localparam int MODE_W = 2;
    localparam int TYPE_W = 16;
    localparam int OP_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int CACHE_DEPTH_DEF   = 16;
    localparam int REQUEST_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF    = 16;

    localparam logic [MS_W-1:0] LIFETIME_RESET = 32'd30000;
    localparam logic [MS_W-1:0] HOLDOFF_RESET  = 32'd5000;

    localparam logic [MAC_W-1:0]  MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [TYPE_W-1:0] ETH_IPV4  = 16'h0800;
    localparam logic [TYPE_W-1:0] ETH_ARP   = 16'h0806;
    localparam logic [OP_W-1:0]   ARP_OP_REQUEST = 16'd1;

    localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    localparam logic [KIND_W-1:0] KIND_IPV4      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ARP_REQ   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARP_REPLY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELIVER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROP      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
        logic [TAG_W-1:0]  handle;
    } res_t;

    typedef struct packed {
        logic [TIME_W-1:0] age;
        logic              gt;
        logic              ge;
    } age_cmp_t;

endpackage

// ===== hdl/arc_age_unit.sv =====
// Shared age unit: one 64-bit subtract and two compares (greater, greater-or-equal) against a limit.
// Depends on arc_pkg.
module arc_age_unit (
    input  logic [arc_pkg::TIME_W-1:0] now,
    input  logic [arc_pkg::TIME_W-1:0] stamp,
    input  logic [arc_pkg::TIME_W-1:0] limit,
    output arc_pkg::age_cmp_t          res
);

    logic [arc_pkg::TIME_W-1:0] age;

    // Ages wrap with the clock, so plain modular subtraction is correct.
    assign age     = now - stamp;
    assign res.age = age;
    assign res.gt  = age > limit;
    assign res.ge  = age >= limit;

endmodule

// ===== hdl/arc_out_reg.sv =====
// Output register of the result channel.
// Depends on arc_pkg.
module arc_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  arc_pkg::res_t load_data,
    input  logic          load_last,
    input  logic          m_ready,
    output logic          m_valid,
    output arc_pkg::res_t m_data,
    output logic          m_last_o,
    output logic          free
);

    logic          valid_reg;
    arc_pkg::res_t data_reg;
    logic          last_reg;

    assign free     = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;
    assign m_last_o = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

endmodule

// ===== hdl/arp_resolver_with_aging_cache.sv =====
// Top level of the ARP resolver: sequencer, tables and configuration.
// Depends on arc_pkg, arc_age_unit and arc_out_reg.
//
//  channel | signals                         | direction
//  s_      | s_valid/s_ready + item fields   | in
//  m_      | m_valid/m_ready + result fields | out
//  cfg_    | cfg_wr_en, cfg_index, cfg_wdata | in, write only
//
// One item at a time; cache and request tables are scanned one entry per cycle through a shared age unit.
// Send scans the cache and, on a miss, the request table, then queues the datagram or drops it.
// ARP scans the cache, writes it, then drains matching queued datagrams; tick ages out both tables.
// A stalled result channel can hold the sequencer.
// Reset is synchronous; valid bits clear at once, no clearing pass.
module arp_resolver_with_aging_cache #(
    parameter int CACHE_DEPTH   = arc_pkg::CACHE_DEPTH_DEF,
    parameter int REQUEST_DEPTH = arc_pkg::REQUEST_DEPTH_DEF,
    parameter int WAIT_DEPTH    = arc_pkg::WAIT_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [arc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arc_pkg::MAC_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [arc_pkg::MODE_W-1:0]    s_mode,
    input  logic [arc_pkg::IP_W-1:0]      s_next_hop_ip,
    input  logic [arc_pkg::TAG_W-1:0]     s_datagram_tag,
    input  logic [arc_pkg::MAC_W-1:0]     s_frame_dst_mac,
    input  logic [arc_pkg::TYPE_W-1:0]    s_frame_type,
    input  logic                          s_payload_ok,
    input  logic [arc_pkg::OP_W-1:0]      s_arp_opcode,
    input  logic [arc_pkg::IP_W-1:0]      s_arp_sender_ip,
    input  logic [arc_pkg::MAC_W-1:0]     s_arp_sender_mac,
    input  logic [arc_pkg::IP_W-1:0]      s_arp_target_ip,
    input  logic [arc_pkg::MS_W-1:0]      s_elapsed_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [arc_pkg::KIND_W-1:0]    m_kind,
    output logic [arc_pkg::MAC_W-1:0]     m_dest_mac,
    output logic [arc_pkg::IP_W-1:0]      m_target_ip_out,
    output logic [arc_pkg::TAG_W-1:0]     m_handle_out,
    output logic                          m_last
);

    localparam int CI = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int RI = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int SW = (CI > RI) ? CI : RI;
    localparam int WI = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC = $clog2(WAIT_DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CSCAN = 4'd1;
    localparam logic [3:0] ST_RSCAN = 4'd2;
    localparam logic [3:0] ST_SREQ  = 4'd3;
    localparam logic [3:0] ST_SQUE  = 4'd4;
    localparam logic [3:0] ST_ASCAN = 4'd5;
    localparam logic [3:0] ST_AWR   = 4'd6;
    localparam logic [3:0] ST_WSCAN = 4'd7;
    localparam logic [3:0] ST_AFIN  = 4'd8;
    localparam logic [3:0] ST_TCACH = 4'd9;
    localparam logic [3:0] ST_TREQ  = 4'd10;
    localparam logic [3:0] ST_FLUSH = 4'd11;

    // Configuration registers.
    logic [arc_pkg::MAC_W-1:0] own_mac_reg;
    logic [arc_pkg::IP_W-1:0]  own_ip_reg;
    logic [arc_pkg::MS_W-1:0]  lifetime_reg;
    logic [arc_pkg::MS_W-1:0]  holdoff_reg;

    // Tables.
    logic [CACHE_DEPTH-1:0]     cache_valid_reg, cache_valid_next;
    logic [arc_pkg::IP_W-1:0]   cache_ip_reg    [CACHE_DEPTH];
    logic [arc_pkg::MAC_W-1:0]  cache_mac_reg   [CACHE_DEPTH];
    logic [arc_pkg::TIME_W-1:0] cache_stamp_reg [CACHE_DEPTH];
    logic [REQUEST_DEPTH-1:0]   req_valid_reg, req_valid_next;
    logic [arc_pkg::IP_W-1:0]   req_ip_reg      [REQUEST_DEPTH];
    logic [arc_pkg::TIME_W-1:0] req_stamp_reg   [REQUEST_DEPTH];
    logic [arc_pkg::IP_W-1:0]   wait_ip_reg     [WAIT_DEPTH];
    logic [arc_pkg::TAG_W-1:0]  wait_tag_reg    [WAIT_DEPTH];

    // Sequencer state.
    logic [3:0]                 state_reg, state_next;
    logic [SW-1:0]              idx_reg, idx_next;
    logic [SW-1:0]              free_reg, free_next;
    logic                       free_found_reg, free_found_next;
    logic [SW-1:0]              best_reg, best_next;
    logic [arc_pkg::TIME_W-1:0] best_age_reg, best_age_next;
    logic [SW-1:0]              match_reg, match_next;
    logic                       match_found_reg, match_found_next;
    logic [WC-1:0]              rd_reg, rd_next;
    logic [WC-1:0]              wr_reg, wr_next;
    logic [WC-1:0]              wait_count_reg, wait_count_next;
    logic [arc_pkg::TIME_W-1:0] time_now_reg, time_now_next;
    arc_pkg::res_t              hold_reg, hold_next;
    logic                       hold_valid_reg, hold_valid_next;

    // Latched item fields.
    logic [arc_pkg::IP_W-1:0]  hop_reg;
    logic [arc_pkg::TAG_W-1:0] tag_reg;
    logic [arc_pkg::OP_W-1:0]  op_reg;
    logic [arc_pkg::IP_W-1:0]  sip_reg;
    logic [arc_pkg::MAC_W-1:0] smac_reg;
    logic [arc_pkg::IP_W-1:0]  tip_reg;

    // Table write controls.
    logic                      cache_we;
    logic [CI-1:0]             cache_wa;
    logic                      req_we;
    logic [RI-1:0]             req_wa;
    logic                      wait_we;
    logic [WI-1:0]             wait_wa;
    logic [arc_pkg::IP_W-1:0]  wait_wip;
    logic [arc_pkg::TAG_W-1:0] wait_wtag;

    logic                       accept;
    logic [CI-1:0]              cidx;
    logic [RI-1:0]              ridx;
    logic [WI-1:0]              rdx;
    logic                       c_last;
    logic                       r_last;
    logic [arc_pkg::TIME_W-1:0] unit_stamp;
    logic [arc_pkg::TIME_W-1:0] unit_limit;
    arc_pkg::age_cmp_t          unit_res;
    logic                       out_load;
    arc_pkg::res_t              out_data;
    logic                       out_last;
    logic                       out_free;
    logic                       can_emit;
    logic                       prod;
    arc_pkg::res_t              prod_data;
    arc_pkg::res_t              m_res;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign cidx    = idx_reg[CI-1:0];
    assign ridx    = idx_reg[RI-1:0];
    assign rdx     = rd_reg[WI-1:0];
    assign c_last  = (cidx == CI'(CACHE_DEPTH - 1));
    assign r_last  = (ridx == RI'(REQUEST_DEPTH - 1));
    assign can_emit = !hold_valid_reg || out_free;

    always_comb begin
        if (state_reg == ST_RSCAN || state_reg == ST_TREQ) begin
            unit_stamp = req_stamp_reg[ridx];
        end else begin
            unit_stamp = cache_stamp_reg[cidx];
        end
        if (state_reg == ST_TCACH) begin
            unit_limit = {32'd0, lifetime_reg};
        end else if (state_reg == ST_TREQ) begin
            unit_limit = {32'd0, holdoff_reg};
        end else begin
            unit_limit = best_age_reg;
        end
    end

    arc_age_unit u_age (
        .now   (time_now_reg),
        .stamp (unit_stamp),
        .limit (unit_limit),
        .res   (unit_res)
    );

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        free_next        = free_reg;
        free_found_next  = free_found_reg;
        best_next        = best_reg;
        best_age_next    = best_age_reg;
        match_next       = match_reg;
        match_found_next = match_found_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        wait_count_next  = wait_count_reg;
        time_now_next    = time_now_reg;
        cache_valid_next = cache_valid_reg;
        req_valid_next   = req_valid_reg;
        cache_we  = 1'b0;
        cache_wa  = cidx;
        req_we    = 1'b0;
        req_wa    = ridx;
        wait_we   = 1'b0;
        wait_wa   = wait_count_reg[WI-1:0];
        wait_wip  = hop_reg;
        wait_wtag = tag_reg;
        prod      = 1'b0;
        prod_data = '0;
        out_load  = 1'b0;
        out_data  = hold_reg;
        out_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next         = '0;
                    free_found_next  = 1'b0;
                    match_found_next = 1'b0;
                    state_next       = ST_FLUSH;
                    case (s_mode)
                        arc_pkg::MODE_SEND: state_next = ST_CSCAN;
                        arc_pkg::MODE_RECV: begin
                            if ((s_frame_dst_mac == own_mac_reg ||
                                 s_frame_dst_mac == arc_pkg::MAC_BCAST) && s_payload_ok) begin
                                if (s_frame_type == arc_pkg::ETH_IPV4) begin
                                    prod             = 1'b1;
                                    prod_data.kind   = arc_pkg::KIND_DELIVER;
                                    prod_data.handle = s_datagram_tag;
                                end else if (s_frame_type == arc_pkg::ETH_ARP) begin
                                    state_next = ST_ASCAN;
                                end
                            end
                        end
                        arc_pkg::MODE_TICK: begin
                            time_now_next = time_now_reg + {32'd0, s_elapsed_ms};
                            state_next    = ST_TCACH;
                        end
                        default: state_next = ST_FLUSH;
                    endcase
                end
            end
            ST_CSCAN: begin
                if (cache_valid_reg[cidx] && cache_ip_reg[cidx] == hop_reg) begin
                    prod             = 1'b1;
                    prod_data.kind   = arc_pkg::KIND_IPV4;
                    prod_data.mac    = cache_mac_reg[cidx];
                    prod_data.handle = tag_reg;
                    state_next       = ST_FLUSH;
                end else if (c_last) begin
                    idx_next   = '0;
                    state_next = ST_RSCAN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RSCAN: begin
                if (req_valid_reg[ridx] && req_ip_reg[ridx] == hop_reg) begin
                    match_found_next = 1'b1;
                end
                if (!free_found_reg && !req_valid_reg[ridx]) begin
                    free_next       = idx_reg;
                    free_found_next = 1'b1;
                end
                // The oldest entry wins; strict compare keeps the lowest index on ties.
                if (ridx == '0 || unit_res.gt) begin
                    best_next     = idx_reg;
                    best_age_next = unit_res.age;
                end
                if (r_last) begin
                    state_next = ST_SREQ;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SREQ: begin
                if (!match_found_reg) begin
                    req_we = 1'b1;
                    req_wa = free_found_reg ? free_reg[RI-1:0] : best_reg[RI-1:0];
                    req_valid_next[req_wa] = 1'b1;
                    prod           = 1'b1;
                    prod_data.kind = arc_pkg::KIND_ARP_REQ;
                    prod_data.mac  = arc_pkg::MAC_BCAST;
                    prod_data.ip   = hop_reg;
                end
                state_next = ST_SQUE;
            end
            ST_SQUE: begin
                if (wait_count_reg < WC'(WAIT_DEPTH)) begin
                    wait_we         = 1'b1;
                    wait_count_next = wait_count_reg + 1'b1;
                    state_next      = ST_FLUSH;
                end else if (can_emit) begin
                    prod             = 1'b1;
                    prod_data.kind   = arc_pkg::KIND_DROP;
                    prod_data.handle = tag_reg;
                    state_next       = ST_FLUSH;
                end
            end
            ST_ASCAN: begin
                if (cache_valid_reg[cidx] && cache_ip_reg[cidx] == sip_reg) begin
                    match_next       = idx_reg;
                    match_found_next = 1'b1;
                end
                if (!free_found_reg && !cache_valid_reg[cidx]) begin
                    free_next       = idx_reg;
                    free_found_next = 1'b1;
                end
                if (cidx == '0 || unit_res.gt) begin
                    best_next     = idx_reg;
                    best_age_next = unit_res.age;
                end
                if (c_last) begin
                    state_next = ST_AWR;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_AWR: begin
                cache_we = 1'b1;
                if (match_found_reg) begin
                    cache_wa = match_reg[CI-1:0];
                end else if (free_found_reg) begin
                    cache_wa = free_reg[CI-1:0];
                end else begin
                    cache_wa = best_reg[CI-1:0];
                end
                cache_valid_next[cache_wa] = 1'b1;
                rd_next    = '0;
                wr_next    = '0;
                state_next = ST_WSCAN;
            end
            ST_WSCAN: begin
                // Matching datagrams leave in queue order; the rest are packed down.
                if (rd_reg == wait_count_reg) begin
                    wait_count_next = wr_reg;
                    state_next      = ST_AFIN;
                end else if (wait_ip_reg[rdx] == sip_reg) begin
                    if (can_emit) begin
                        prod             = 1'b1;
                        prod_data.kind   = arc_pkg::KIND_IPV4;
                        prod_data.mac    = smac_reg;
                        prod_data.handle = wait_tag_reg[rdx];
                        rd_next          = rd_reg + 1'b1;
                    end
                end else begin
                    wait_we   = 1'b1;
                    wait_wa   = wr_reg[WI-1:0];
                    wait_wip  = wait_ip_reg[rdx];
                    wait_wtag = wait_tag_reg[rdx];
                    wr_next   = wr_reg + 1'b1;
                    rd_next   = rd_reg + 1'b1;
                end
            end
            ST_AFIN: begin
                if (op_reg == arc_pkg::ARP_OP_REQUEST && tip_reg == own_ip_reg) begin
                    if (can_emit) begin
                        prod           = 1'b1;
                        prod_data.kind = arc_pkg::KIND_ARP_REPLY;
                        prod_data.mac  = smac_reg;
                        prod_data.ip   = sip_reg;
                        state_next     = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_TCACH: begin
                if (cache_valid_reg[cidx] && unit_res.ge) begin
                    cache_valid_next[cidx] = 1'b0;
                end
                if (c_last) begin
                    idx_next   = '0;
                    state_next = ST_TREQ;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TREQ: begin
                if (req_valid_reg[ridx] && unit_res.ge) begin
                    req_valid_next[ridx] = 1'b0;
                end
                if (r_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                // The held result is the final one of the item.
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // A new result pushes the held one out as a non-final result.
    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (prod) begin
            hold_next       = prod_data;
            hold_valid_next = 1'b1;
        end else if (out_load) begin
            hold_valid_next = 1'b0;
        end
    end

    logic push_hold;
    assign push_hold = prod && hold_valid_reg;

    arc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load || push_hold),
        .load_data (out_data),
        .load_last (out_last),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_res),
        .m_last_o  (m_last),
        .free      (out_free)
    );

    assign m_kind          = m_res.kind;
    assign m_dest_mac      = m_res.mac;
    assign m_target_ip_out = m_res.ip;
    assign m_handle_out    = m_res.handle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            hold_valid_reg  <= 1'b0;
            cache_valid_reg <= '0;
            req_valid_reg   <= '0;
            wait_count_reg  <= '0;
            time_now_reg    <= '0;
            own_mac_reg     <= '0;
            own_ip_reg      <= '0;
            lifetime_reg    <= arc_pkg::LIFETIME_RESET;
            holdoff_reg     <= arc_pkg::HOLDOFF_RESET;
        end else begin
            state_reg       <= state_next;
            hold_valid_reg  <= hold_valid_next;
            cache_valid_reg <= cache_valid_next;
            req_valid_reg   <= req_valid_next;
            wait_count_reg  <= wait_count_next;
            time_now_reg    <= time_now_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    arc_pkg::CFG_OWN_MAC:  own_mac_reg  <= cfg_wdata;
                    arc_pkg::CFG_OWN_IP:   own_ip_reg   <= cfg_wdata[arc_pkg::IP_W-1:0];
                    arc_pkg::CFG_LIFETIME: lifetime_reg <= cfg_wdata[arc_pkg::MS_W-1:0];
                    arc_pkg::CFG_HOLDOFF:  holdoff_reg  <= cfg_wdata[arc_pkg::MS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        free_reg        <= free_next;
        free_found_reg  <= free_found_next;
        best_reg        <= best_next;
        best_age_reg    <= best_age_next;
        match_reg       <= match_next;
        match_found_reg <= match_found_next;
        rd_reg          <= rd_next;
        wr_reg          <= wr_next;
        hold_reg        <= hold_next;
        if (accept) begin
            hop_reg  <= s_next_hop_ip;
            tag_reg  <= s_datagram_tag;
            op_reg   <= s_arp_opcode;
            sip_reg  <= s_arp_sender_ip;
            smac_reg <= s_arp_sender_mac;
            tip_reg  <= s_arp_target_ip;
        end
        if (cache_we) begin
            cache_ip_reg[cache_wa]    <= sip_reg;
            cache_mac_reg[cache_wa]   <= smac_reg;
            cache_stamp_reg[cache_wa] <= time_now_reg;
        end
        if (req_we) begin
            req_ip_reg[req_wa]    <= hop_reg;
            req_stamp_reg[req_wa] <= time_now_reg;
        end
        if (wait_we) begin
            wait_ip_reg[wait_wa]  <= wait_wip;
            wait_tag_reg[wait_wa] <= wait_wtag;
        end
    end

endmodule

// ===== hdl/arc_checker.sv =====
// Port-level checker of the ARP resolver, bound to the top level.
// Depends on arc_pkg and arp_resolver_with_aging_cache_defines.svh.
`include "arp_resolver_with_aging_cache_defines.svh"

module arc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [arc_pkg::KIND_W-1:0]    m_kind,
    input logic [arc_pkg::MAC_W-1:0]     m_dest_mac,
    input logic [arc_pkg::TAG_W-1:0]     m_handle_out,
    input logic                          m_last
);

    // An accepted item keeps the block busy in the following cycle.
    `ARC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    `ARC_ASSERT_NOW(a_kind_range, m_valid, m_kind <= arc_pkg::KIND_DROP, "kind out of range")

    // A request always goes to broadcast.
    `ARC_ASSERT_NOW(a_req_bcast, m_valid && m_kind == arc_pkg::KIND_ARP_REQ,
        m_dest_mac == arc_pkg::MAC_BCAST && m_handle_out == '0, "request not broadcast")

    `ARC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_kind) && $stable(m_last), "stalled result changed")

endmodule

bind arp_resolver_with_aging_cache arc_checker u_arc_checker (.*);
